>>> hdl/postfix_stack_evaluator_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the postfix stack evaluator
// Shared property forms. Each one is sampled on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef POSTFIX_STACK_EVALUATOR_UNIT_ASSERT_SVH
`define POSTFIX_STACK_EVALUATOR_UNIT_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define PSE_CHECK_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define PSE_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/pse_pkg.sv
// ----------------------------------------------------------------------------
// pse_pkg
// Types, codes and helpers shared by the postfix stack evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package pse_pkg;

    localparam int STACK_DEPTH_DEF   = 16;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int DATA_W            = 32;
    localparam int OP_W              = 3;
    localparam int COUNT_W           = 5;
    localparam int STATUS_W          = 3;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 3'd0,
        OP_ADD   = 3'd1,
        OP_SUB   = 3'd2,
        OP_MUL   = 3'd3,
        OP_DIV   = 3'd4,
        OP_CLEAR = 3'd5
    } op_code_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_UNDERFLOW = 3'd1,
        ST_FULL      = 3'd2,
        ST_DIVZERO   = 3'd3,
        ST_SATURATED = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CLS_PUSH,
        CLS_ARITH,
        CLS_CLEAR,
        CLS_IGNORE
    } token_class_t;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV
    } alu_op_t;

    typedef struct packed {
        token_class_t              cls;
        alu_op_t                   alu;
        logic signed [DATA_W-1:0]  value;
    } token_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_READ,
        BK_EXEC,
        BK_MUL,
        BK_DIV_CHECK,
        BK_DIV_RUN,
        BK_COMMIT
    } back_state_t;

    typedef struct packed {
        logic                      sat;
        logic signed [DATA_W-1:0]  value;
    } clamp_t;

    // Clamps a 64-bit signed value into the 32-bit word range.
    function automatic clamp_t clamp_word(input logic signed [2*DATA_W-1:0] v);
        clamp_t                r;
        logic [DATA_W:0]       upper;
        upper = v[2*DATA_W-1:DATA_W-1];
        if ((&upper) || (~|upper)) begin
            r.sat   = 1'b0;
            r.value = v[DATA_W-1:0];
        end
        else begin
            r.sat   = 1'b1;
            r.value = v[2*DATA_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                    : {1'b0, {(DATA_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hdl/pse_channels.sv
// ----------------------------------------------------------------------------
// pse channels
// Valid/ready channels for tokens into the evaluator and results out of it.
// ----------------------------------------------------------------------------
`default_nettype none

interface pse_token_if;
    logic                                valid;
    logic                                ready;
    logic [pse_pkg::OP_W-1:0]            operation;
    logic signed [pse_pkg::DATA_W-1:0]   operand_value;

    modport source (output valid, output operation, output operand_value, input ready);
    modport sink   (input valid, input operation, input operand_value, output ready);
endinterface

interface pse_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [pse_pkg::DATA_W-1:0]   top_value;
    logic [pse_pkg::COUNT_W-1:0]         stack_count;
    logic [pse_pkg::STATUS_W-1:0]        status;

    modport source (output valid, output top_value, output stack_count, output status,
                    input ready);
    modport sink   (input valid, input top_value, input stack_count, input status,
                    output ready);
endinterface

`default_nettype wire

>>> hdl/pse_ram.sv
// ----------------------------------------------------------------------------
// pse_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pse_ram #(
    parameter int WIDTH = pse_pkg::DATA_W,
    parameter int DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      we,
    input  wire logic [$clog2(DEPTH)-1:0]  waddr,
    input  wire logic [WIDTH-1:0]          wdata,
    input  wire logic                      re,
    input  wire logic [$clog2(DEPTH)-1:0]  raddr,
    output logic      [WIDTH-1:0]          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

>>> hdl/pse_divider.sv
// ----------------------------------------------------------------------------
// pse_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pse_divider (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [2*pse_pkg::DATA_W-1:0]    dividend,
    input  wire logic [pse_pkg::DATA_W-1:0]      divisor,
    output logic                                 done,
    output logic      [pse_pkg::DATA_W-1:0]      quotient
);

    localparam int W     = pse_pkg::DATA_W;
    localparam int CNT_W = $clog2(W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     quo_reg, quo_next;
    logic [W-1:0]     dsr_reg, dsr_next;
    logic [W:0]       trial;
    logic             fits;

    // The caller guarantees that the upper half of the dividend is below the
    // divisor, so the quotient fits in one word.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        trial     = {rem_reg, quo_reg[W-1]};
        fits      = (trial >= {1'b0, dsr_reg});
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = dividend[2*W-1:W];
            quo_next  = dividend[W-1:0];
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? W'(trial - {1'b0, dsr_reg}) : trial[W-1:0];
            quo_next = {quo_reg[W-2:0], fits};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

>>> hdl/pse_front.sv
// ----------------------------------------------------------------------------
// pse_front
// Accepts tokens, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module pse_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    pse_token_if.sink          token,
    output logic               q_valid,
    output pse_pkg::token_t    q_entry,
    input  wire logic          q_pop
);

    pse_pkg::token_t entry_reg [2];
    pse_pkg::token_t entry_next;
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      fill_reg, fill_next;
    logic            do_push, do_pop;

    assign token.ready = (fill_reg != 2'd2);
    assign q_valid     = (fill_reg != 2'd0);
    assign q_entry     = entry_reg[rd_ptr_reg];
    assign do_push     = token.valid && token.ready;
    assign do_pop      = q_pop && q_valid;

    always_comb
    begin
        entry_next.value = token.operand_value;
        entry_next.alu   = pse_pkg::ALU_ADD;
        unique case (pse_pkg::op_code_t'(token.operation))
            pse_pkg::OP_PUSH:  entry_next.cls = pse_pkg::CLS_PUSH;
            pse_pkg::OP_ADD:
            begin
                entry_next.cls = pse_pkg::CLS_ARITH;
                entry_next.alu = pse_pkg::ALU_ADD;
            end
            pse_pkg::OP_SUB:
            begin
                entry_next.cls = pse_pkg::CLS_ARITH;
                entry_next.alu = pse_pkg::ALU_SUB;
            end
            pse_pkg::OP_MUL:
            begin
                entry_next.cls = pse_pkg::CLS_ARITH;
                entry_next.alu = pse_pkg::ALU_MUL;
            end
            pse_pkg::OP_DIV:
            begin
                entry_next.cls = pse_pkg::CLS_ARITH;
                entry_next.alu = pse_pkg::ALU_DIV;
            end
            pse_pkg::OP_CLEAR: entry_next.cls = pse_pkg::CLS_CLEAR;
            default:           entry_next.cls = pse_pkg::CLS_IGNORE;
        endcase
    end

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop  ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= entry_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/pse_back.sv
// ----------------------------------------------------------------------------
// pse_back
// Stack engine: carries out queued tokens and registers one result each.
// ----------------------------------------------------------------------------
`default_nettype none

module pse_back #(
    parameter int STACK_DEPTH   = pse_pkg::STACK_DEPTH_DEF,
    parameter int FRACTION_BITS = pse_pkg::FRACTION_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_valid,
    input  wire pse_pkg::token_t    q_entry,
    output logic                    q_pop,
    pse_result_if.source            result
);

    localparam int W       = pse_pkg::DATA_W;
    localparam int IDX_W   = $clog2(STACK_DEPTH);
    localparam int SP_W    = $clog2(STACK_DEPTH + 1);
    localparam int COUNT_W = pse_pkg::COUNT_W;

    localparam logic [W-1:0] WORD_MIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] WORD_MAX = {1'b0, {(W-1){1'b1}}};

    pse_pkg::back_state_t   state_reg, state_next;
    logic [SP_W-1:0]        sp_reg, sp_next;
    logic signed [W-1:0]    top_reg, top_next;
    logic signed [W-1:0]    left_reg, left_next;
    pse_pkg::alu_op_t       alu_reg, alu_next;
    logic signed [2*W-1:0]  prod_reg, prod_next;
    logic [W-1:0]           mag_l_reg, mag_l_next;
    logic [W-1:0]           mag_r_reg, mag_r_next;
    logic                   neg_reg, neg_next;
    logic signed [W-1:0]    res_val_reg, res_val_next;
    pse_pkg::status_t       res_status_reg, res_status_next;

    logic                   out_valid_reg, out_valid_next;
    logic signed [W-1:0]    out_top_reg, out_top_next;
    logic [COUNT_W-1:0]     out_count_reg, out_count_next;
    pse_pkg::status_t       out_status_reg, out_status_next;

    logic                   res_free;
    logic                   arith_go;
    logic                   emit;
    pse_pkg::status_t       emit_status;

    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic                   ram_re;
    logic [IDX_W-1:0]       ram_raddr;
    logic [W-1:0]           ram_rdata;

    logic                   div_start;
    logic                   div_done;
    logic [W-1:0]           div_quotient;
    logic [2*W-1:0]         div_dividend;

    logic signed [W:0]      addsub;
    pse_pkg::clamp_t        clamped;

    assign res_free     = !out_valid_reg || result.ready;
    assign arith_go     = (q_entry.cls == pse_pkg::CLS_ARITH) && (sp_reg >= SP_W'(2));
    assign div_dividend = (2*W)'(mag_l_reg) << FRACTION_BITS;
    assign ram_waddr    = IDX_W'(sp_reg - SP_W'(1));
    assign ram_raddr    = IDX_W'(sp_reg - SP_W'(2));

    pse_ram #(
        .WIDTH (W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (top_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pse_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (mag_r_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pse_pkg::BK_IDLE:
            begin
                if (q_valid && arith_go)
                begin
                    state_next = pse_pkg::BK_READ;
                end
            end
            pse_pkg::BK_READ:
            begin
                state_next = pse_pkg::BK_EXEC;
            end
            pse_pkg::BK_EXEC:
            begin
                unique case (alu_reg)
                    pse_pkg::ALU_MUL: state_next = pse_pkg::BK_MUL;
                    pse_pkg::ALU_DIV: state_next = (top_reg == '0) ? pse_pkg::BK_COMMIT
                                                                   : pse_pkg::BK_DIV_CHECK;
                    default:          state_next = pse_pkg::BK_COMMIT;
                endcase
            end
            pse_pkg::BK_MUL:
            begin
                state_next = pse_pkg::BK_COMMIT;
            end
            pse_pkg::BK_DIV_CHECK:
            begin
                state_next = (div_dividend[2*W-1:W] >= mag_r_reg) ? pse_pkg::BK_COMMIT
                                                                 : pse_pkg::BK_DIV_RUN;
            end
            pse_pkg::BK_DIV_RUN:
            begin
                if (div_done)
                begin
                    state_next = pse_pkg::BK_COMMIT;
                end
            end
            pse_pkg::BK_COMMIT:
            begin
                if (res_free)
                begin
                    state_next = pse_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = pse_pkg::BK_IDLE;
            end
        endcase
    end

    // Outputs and datapath.
    always_comb
    begin
        sp_next         = sp_reg;
        top_next        = top_reg;
        left_next       = left_reg;
        alu_next        = alu_reg;
        prod_next       = prod_reg;
        mag_l_next      = mag_l_reg;
        mag_r_next      = mag_r_reg;
        neg_next        = neg_reg;
        res_val_next    = res_val_reg;
        res_status_next = res_status_reg;
        q_pop           = 1'b0;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        div_start       = 1'b0;
        emit            = 1'b0;
        emit_status     = pse_pkg::ST_OK;
        addsub          = '0;
        clamped         = '0;

        unique case (state_reg)
            pse_pkg::BK_IDLE:
            begin
                if (q_valid && (arith_go || res_free))
                begin
                    q_pop = 1'b1;
                    unique case (q_entry.cls)
                        pse_pkg::CLS_PUSH:
                        begin
                            emit = 1'b1;
                            if (sp_reg == SP_W'(STACK_DEPTH))
                            begin
                                emit_status = pse_pkg::ST_FULL;
                            end
                            else
                            begin
                                // The old top moves down into the memory.
                                ram_we   = (sp_reg != '0);
                                top_next = q_entry.value;
                                sp_next  = sp_reg + SP_W'(1);
                            end
                        end
                        pse_pkg::CLS_ARITH:
                        begin
                            if (arith_go)
                            begin
                                ram_re   = 1'b1;
                                alu_next = q_entry.alu;
                            end
                            else
                            begin
                                emit        = 1'b1;
                                emit_status = pse_pkg::ST_UNDERFLOW;
                            end
                        end
                        pse_pkg::CLS_CLEAR:
                        begin
                            emit    = 1'b1;
                            sp_next = '0;
                        end
                        default:
                        begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            pse_pkg::BK_READ:
            begin
                left_next = ram_rdata;
            end
            pse_pkg::BK_EXEC:
            begin
                res_status_next = pse_pkg::ST_OK;
                unique case (alu_reg)
                    pse_pkg::ALU_ADD, pse_pkg::ALU_SUB:
                    begin
                        addsub = (alu_reg == pse_pkg::ALU_ADD)
                               ? ({left_reg[W-1], left_reg} + {top_reg[W-1], top_reg})
                               : ({left_reg[W-1], left_reg} - {top_reg[W-1], top_reg});
                        clamped = pse_pkg::clamp_word((2*W)'(addsub));
                        res_val_next = clamped.value;
                        if (clamped.sat)
                        begin
                            res_status_next = pse_pkg::ST_SATURATED;
                        end
                    end
                    pse_pkg::ALU_MUL:
                    begin
                        prod_next = left_reg * top_reg;
                    end
                    default:
                    begin
                        if (top_reg == '0)
                        begin
                            res_status_next = pse_pkg::ST_DIVZERO;
                        end
                        mag_l_next = left_reg[W-1] ? W'(-left_reg) : left_reg;
                        mag_r_next = top_reg[W-1]  ? W'(-top_reg)  : top_reg;
                        neg_next   = left_reg[W-1] ^ top_reg[W-1];
                    end
                endcase
            end
            pse_pkg::BK_MUL:
            begin
                // Arithmetic shift floors toward minus infinity.
                clamped      = pse_pkg::clamp_word(prod_reg >>> FRACTION_BITS);
                res_val_next = clamped.value;
                if (clamped.sat)
                begin
                    res_status_next = pse_pkg::ST_SATURATED;
                end
            end
            pse_pkg::BK_DIV_CHECK:
            begin
                // A quotient of 2^32 or more cannot fit; saturate right away.
                if (div_dividend[2*W-1:W] >= mag_r_reg)
                begin
                    res_val_next    = neg_reg ? WORD_MIN : WORD_MAX;
                    res_status_next = pse_pkg::ST_SATURATED;
                end
                else
                begin
                    div_start = 1'b1;
                end
            end
            pse_pkg::BK_DIV_RUN:
            begin
                if (div_done)
                begin
                    if (neg_reg)
                    begin
                        if (div_quotient > WORD_MIN)
                        begin
                            res_val_next    = WORD_MIN;
                            res_status_next = pse_pkg::ST_SATURATED;
                        end
                        else
                        begin
                            res_val_next = W'(-div_quotient);
                        end
                    end
                    else if (div_quotient[W-1])
                    begin
                        res_val_next    = WORD_MAX;
                        res_status_next = pse_pkg::ST_SATURATED;
                    end
                    else
                    begin
                        res_val_next = div_quotient;
                    end
                end
            end
            pse_pkg::BK_COMMIT:
            begin
                if (res_free)
                begin
                    emit        = 1'b1;
                    emit_status = res_status_reg;
                    if (res_status_reg != pse_pkg::ST_DIVZERO)
                    begin
                        sp_next  = sp_reg - SP_W'(1);
                        top_next = res_val_reg;
                    end
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // Result register: a new result may load in the same cycle the old one
    // completes its transfer.
    always_comb
    begin
        out_valid_next  = out_valid_reg && !result.ready;
        out_top_next    = out_top_reg;
        out_count_next  = out_count_reg;
        out_status_next = out_status_reg;
        if (emit)
        begin
            out_valid_next  = 1'b1;
            out_top_next    = (sp_next == '0) ? '0 : top_next;
            out_count_next  = COUNT_W'(sp_next);
            out_status_next = emit_status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pse_pkg::BK_IDLE;
            sp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg        <= top_next;
        left_reg       <= left_next;
        alu_reg        <= alu_next;
        prod_reg       <= prod_next;
        mag_l_reg      <= mag_l_next;
        mag_r_reg      <= mag_r_next;
        neg_reg        <= neg_next;
        res_val_reg    <= res_val_next;
        res_status_reg <= res_status_next;
        out_top_reg    <= out_top_next;
        out_count_reg  <= out_count_next;
        out_status_reg <= out_status_next;
    end

    assign result.valid       = out_valid_reg;
    assign result.top_value   = out_top_reg;
    assign result.stack_count = out_count_reg;
    assign result.status      = out_status_reg;

endmodule

`default_nettype wire

>>> hdl/postfix_stack_evaluator_unit.sv
// ----------------------------------------------------------------------------
// postfix_stack_evaluator_unit
// Reverse Polish evaluator on a stack of signed fixed-point values.
// ----------------------------------------------------------------------------
// Each token on the token channel gives exactly one transfer on the result
// channel: the top of stack afterwards (zero when empty), the entry count and
// a status. A two-entry queue decouples token acceptance from execution, and
// the result register lets a new result load while the previous one is taken.
// Push, clear, ignored codes and rejected operations finish in the idle state
// of the stack engine. Add and subtract go through read, execute and commit;
// the read waits on the registered read of the stack memory below the cached
// top entry, and multiply adds a state for the registered 32x32 multiplier.
// Divide runs the divider, which makes one quotient bit per cycle; a divide
// by zero commits after execute, an overflow after the check. Values carry
// FRACTION_BITS fraction bits; results outside 32 bits saturate with status 4.
`default_nettype none

module postfix_stack_evaluator_unit #(
    parameter int STACK_DEPTH   = pse_pkg::STACK_DEPTH_DEF,
    parameter int FRACTION_BITS = pse_pkg::FRACTION_BITS_DEF
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    pse_token_if.sink      token,
    pse_result_if.source   result
);

    logic            q_valid;
    logic            q_pop;
    pse_pkg::token_t q_entry;

    pse_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .token   (token),
        .q_valid (q_valid),
        .q_entry (q_entry),
        .q_pop   (q_pop)
    );

    pse_back #(
        .STACK_DEPTH   (STACK_DEPTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_entry (q_entry),
        .q_pop   (q_pop),
        .result  (result)
    );

endmodule

`default_nettype wire

>>> hdl/pse_checker.sv
// ----------------------------------------------------------------------------
// pse_checker
// Port-level checks of the evaluator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "postfix_stack_evaluator_unit_assert.svh"

module pse_checker #(
    parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                out_valid,
    input wire logic                                out_ready,
    input wire logic signed [pse_pkg::DATA_W-1:0]   top_value,
    input wire logic [pse_pkg::COUNT_W-1:0]         stack_count,
    input wire logic [pse_pkg::STATUS_W-1:0]        status
);

    localparam int COUNT_W = pse_pkg::COUNT_W;
    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(STACK_DEPTH);
    localparam logic COUNT_EXACT = (STACK_DEPTH < (1 << COUNT_W));

    `PSE_CHECK_NEXT(a_result_held, out_valid && !out_ready,
        out_valid && $stable(top_value) && $stable(stack_count) && $stable(status),
        "result changed before its transfer")

    `PSE_CHECK_SAME(a_full_count, out_valid && (status == pse_pkg::ST_FULL),
        stack_count == FULL_COUNT, "stack full reported below full depth")

    `PSE_CHECK_SAME(a_underflow_count, out_valid && (status == pse_pkg::ST_UNDERFLOW),
        stack_count < COUNT_W'(2), "underflow reported with two or more entries")

    `PSE_CHECK_SAME(a_empty_top, out_valid && COUNT_EXACT && (stack_count == '0),
        top_value == '0, "empty stack with nonzero top")

endmodule

bind postfix_stack_evaluator_unit pse_checker #(
    .STACK_DEPTH (STACK_DEPTH)
) u_pse_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .top_value   (result.top_value),
    .stack_count (result.stack_count),
    .status      (result.status)
);

`default_nettype wire

>>> test/tb_postfix_stack_evaluator_unit.sv
// ----------------------------------------------------------------------------
// tb_postfix_stack_evaluator_unit
// Checks the postfix stack evaluator token by token against a shadow stack.
// Directed tokens cover the value extremes, every operation and the error
// cases. Random expressions with some noise follow. Both channels idle at
// random, and one long receiver hold-off fills the block so that it stalls
// its token input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_postfix_stack_evaluator_unit;

    import pse_pkg::*;

    localparam int DEPTH          = STACK_DEPTH_DEF;
    localparam int FRAC_BITS      = FRACTION_BITS_DEF;
    localparam int CLK_PERIOD     = 12;
    localparam int TIMEOUT_CYCLES = 800000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int HOLD_CYCLES    = 400;

    // Codes outside the operation set; the block must ignore them.
    localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

    localparam longint WORD_MAX = 64'sd2147483647;
    localparam longint WORD_MIN = -(64'sd2147483648);

    typedef struct {
        logic signed [DATA_W-1:0] top;
        logic [COUNT_W-1:0]       count;
        status_t                  status;
    } stack_view_t;

    logic clk = 1'b0;
    logic rst_n;

    pse_token_if  token_ch ();
    pse_result_if result_ch ();

    postfix_stack_evaluator_unit #(
        .STACK_DEPTH   (DEPTH),
        .FRACTION_BITS (FRAC_BITS)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .token  (token_ch),
        .result (result_ch)
    );

    // Shadow copy of the operand stack.
    logic signed [DATA_W-1:0] model_stack [DEPTH];
    int                       model_depth = 0;

    stack_view_t pending_results [$];
    int          mismatch_count = 0;
    bit          no_idle        = 1'b0;
    int          sink_hold_req  = 0;

    always
    begin
        #(CLK_PERIOD / 2) clk = 1'b1;
        #(CLK_PERIOD / 2) clk = 1'b0;
    end

    // Applies one token to the shadow stack and returns the view it leaves.
    function automatic stack_view_t apply_token(input logic [OP_W-1:0] op,
                                                input logic signed [DATA_W-1:0] value);
        stack_view_t view;
        longint      left;
        longint      right;
        longint      wide;
        bit          do_write;
        view.status = ST_OK;
        do_write    = 1'b0;
        wide        = 0;
        case (op)
            OP_PUSH:
            begin
                if (model_depth >= DEPTH)
                    view.status = ST_FULL;
                else
                begin
                    model_stack[model_depth] = value;
                    model_depth++;
                end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV:
            begin
                if (model_depth < 2)
                    view.status = ST_UNDERFLOW;
                else
                begin
                    left  = model_stack[model_depth - 2];
                    right = model_stack[model_depth - 1];
                    case (op)
                        OP_ADD:
                        begin
                            wide     = left + right;
                            do_write = 1'b1;
                        end
                        OP_SUB:
                        begin
                            wide     = left - right;
                            do_write = 1'b1;
                        end
                        OP_MUL:
                        begin
                            // Arithmetic shift of the full product rounds toward minus infinity.
                            wide     = (left * right) >>> FRAC_BITS;
                            do_write = 1'b1;
                        end
                        default:
                        begin
                            if (right == 0)
                                view.status = ST_DIVZERO;
                            else
                            begin
                                wide     = (left <<< FRAC_BITS) / right;
                                do_write = 1'b1;
                            end
                        end
                    endcase
                    if (do_write)
                    begin
                        if (wide > WORD_MAX)
                        begin
                            wide        = WORD_MAX;
                            view.status = ST_SATURATED;
                        end
                        else if (wide < WORD_MIN)
                        begin
                            wide        = WORD_MIN;
                            view.status = ST_SATURATED;
                        end
                        model_depth--;
                        model_stack[model_depth - 1] = wide[DATA_W-1:0];
                    end
                end
            end
            OP_CLEAR:
                model_depth = 0;
            default:
                ;
        endcase
        view.top   = (model_depth == 0) ? '0 : model_stack[model_depth - 1];
        view.count = COUNT_W'(model_depth);
        return view;
    endfunction

    function automatic int source_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int sink_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_operand();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return '0;
            1:
            begin
                case ($urandom_range(0, 5))
                    0:       return 32'sh7FFFFFFF;
                    1:       return 32'sh80000000;
                    2:       return 32'sh00000001;
                    3:       return 32'shFFFFFFFF;
                    4:       return 32'sh00010000;
                    default: return 32'shFFFF0000;
                endcase
            end
            2, 3, 4: return $urandom;
            // Small values keep most expressions away from saturation.
            default: return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
        endcase
    endfunction

    // Offers one token after a random gap and holds it until the transfer.
    task automatic send_token(input logic [OP_W-1:0] op,
                              input logic signed [DATA_W-1:0] value);
        int gap;
        gap = source_gap();
        if (gap > 0)
        begin
            token_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        token_ch.valid         <= 1'b1;
        token_ch.operation     <= op;
        token_ch.operand_value <= value;
        do
            @(posedge clk);
        while (token_ch.ready !== 1'b1);
        pending_results.push_back(apply_token(op, value));
    endtask

    task automatic test_directed_cases();
        send_token(OP_ADD, 32'sh0);                  // underflow on an empty stack
        send_token(OP_PUSH, 32'sh7FFFFFFF);
        send_token(OP_SUB, 32'sh12345678);           // underflow with one entry
        send_token(OP_PUSH, 32'sh7FFFFFFF);
        send_token(OP_ADD, 32'sh0);                  // saturates high
        send_token(OP_PUSH, 32'sh80000000);
        send_token(OP_SUB, 32'sh0);                  // saturates high
        send_token(OP_PUSH, 32'sh80000000);
        send_token(OP_MUL, 32'sh0);                  // saturates low
        send_token(OP_PUSH, 32'sh0);
        send_token(OP_DIV, 32'sh0);                  // divide by zero keeps both entries
        send_token(OP_CLEAR, 32'shFFFFFFFF);
        send_token(OP_RSVD_6, 32'sh7FFFFFFF);
        send_token(OP_RSVD_7, 32'sh80000000);
        send_token(OP_PUSH, 32'sh00018000);
        send_token(OP_PUSH, 32'shFFFFFFFF);
        send_token(OP_MUL, 32'sh0);                  // product rounds down
        send_token(OP_PUSH, 32'sh00030000);
        send_token(OP_DIV, 32'sh0);                  // quotient truncates toward zero
        send_token(OP_PUSH, 32'sh80000000);
        send_token(OP_PUSH, 32'shFFFFFFFF);
        send_token(OP_DIV, 32'sh0);                  // quotient saturates high
        send_token(OP_PUSH, 32'sh00010000);
        send_token(OP_SUB, 32'sh0);
        send_token(OP_CLEAR, 32'sh0);
    endtask

    task automatic test_stack_full();
        int i;
        for (i = 0; i < DEPTH; i++)
            send_token(OP_PUSH, (i % 3 == 0) ? 32'sh7FFFFFFF : pick_operand());
        send_token(OP_PUSH, 32'sh55555555);          // one push too many
        send_token(OP_RSVD_7, 32'sh0);               // ignored with a full stack
        for (i = 0; i < DEPTH - 1; i++)
            send_token(3'($urandom_range(OP_ADD, OP_DIV)), 32'sh0);
        send_token(OP_ADD, 32'sh0);                  // one entry left unless a divide by zero kept entries
        send_token(OP_CLEAR, 32'sh0);
    endtask

    task automatic test_random_expressions(input int item_total);
        int              issued;
        int              pick;
        logic [OP_W-1:0] op;
        issued = 0;
        while (issued < item_total)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                op = 3'($urandom_range(0, 7));
            else if (pick < 11)
                op = OP_CLEAR;
            else if (model_depth < 2)
                op = OP_PUSH;
            else if (model_depth >= DEPTH)
                op = 3'($urandom_range(OP_ADD, OP_DIV));
            else if (pick < 56)
                op = OP_PUSH;
            else
                op = 3'($urandom_range(OP_ADD, OP_DIV));
            send_token(op, pick_operand());
            issued++;
        end
    endtask

    task automatic test_back_pressure();
        sink_hold_req <= HOLD_CYCLES;
        no_idle = 1'b1;
        test_random_expressions(40);
        no_idle = 1'b0;
    endtask

    task automatic test_no_idle_stretch();
        no_idle = 1'b1;
        test_random_expressions(120);
        no_idle = 1'b0;
    endtask

    // Receiver: random stalls, plus a long hold-off on request.
    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (sink_hold_req > 0)
            begin
                stall_left    = sink_hold_req;
                sink_hold_req = 0;
            end
            else if (stall_left == 0 && !no_idle && $urandom_range(0, 3) == 0)
                stall_left = sink_gap();
            if (stall_left > 0)
            begin
                result_ch.ready <= 1'b0;
                stall_left--;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : result_check
        stack_view_t want;
        if (rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transfer with no token pending: top_value %0d",
                       result_ch.top_value);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result_ch.top_value !== want.top)
                begin
                    $error("top_value mismatch: expected %0d, actual %0d",
                           want.top, result_ch.top_value);
                    mismatch_count++;
                end
                if (result_ch.stack_count !== want.count)
                begin
                    $error("stack_count mismatch: expected %0d, actual %0d",
                           want.count, result_ch.stack_count);
                    mismatch_count++;
                end
                if (result_ch.status !== want.status)
                begin
                    $error("status mismatch: expected %0d, actual %0d",
                           want.status, result_ch.status);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("FAIL");
        $finish;
    end

    initial
    begin
        rst_n                  <= 1'b0;
        token_ch.valid         <= 1'b0;
        token_ch.operation     <= OP_PUSH;
        token_ch.operand_value <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_stack_full();
        test_random_expressions(350);
        test_back_pressure();
        test_random_expressions(350);
        test_no_idle_stretch();

        token_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
